// File: rtl/worley_noise_2d_manhattan_q15_top_assert.svh
// Assertion macros for the worley noise block.
// Expects clk and arst_n in the scope of use.
`ifndef WORLEY_NOISE_2D_MANHATTAN_Q15_TOP_ASSERT_SVH
`define WORLEY_NOISE_2D_MANHATTAN_Q15_TOP_ASSERT_SVH

// same-cycle implication
`define WN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/wn2d_pkg.sv
// Constants, types and helpers for the worley noise pipeline.
// No dependencies.
package wn2d_pkg;

	typedef logic [31:0] word_t;
	typedef logic [16:0] dist_t;
	typedef logic [14:0] frac_t;

	localparam int unsigned LANES = 9;
	localparam int unsigned ROWS  = 3;

	localparam word_t HASH_MUL_X = 32'd374761393;
	localparam word_t HASH_MUL_Y = 32'd668265263;
	localparam word_t HASH_MIX   = 32'd1274126177;

	// hash term for neighbor offset -1, 0, +1 (idx 0, 1, 2)
	function automatic word_t hash_off(input logic [1:0] idx, input word_t mul);
		case (idx)
			2'd0: hash_off = 32'd0 - mul;
			2'd1: hash_off = 32'd0;
			default: hash_off = mul;
		endcase
	endfunction

	// cell origin offset in Q15 for neighbor idx
	function automatic logic signed [17:0] cell_off(input logic [1:0] idx);
		case (idx)
			2'd0: cell_off = -18'sd32768;
			2'd1: cell_off = 18'sd0;
			default: cell_off = 18'sd32768;
		endcase
	endfunction

	function automatic dist_t dmin(input dist_t a, input dist_t b);
		dmin = (b < a) ? b : a;
	endfunction

endpackage

// File: rtl/worley_noise_2d_manhattan_q15_top.sv
// Worley cellular noise, 2D, Manhattan metric, Q15 coordinates.
// Uses wn2d_pkg and worley_noise_2d_manhattan_q15_top_assert.svh.
//
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  in      | in_valid, in_stall, x_pos, y_pos | sink
//  out     | out_valid, out_stall, noise_value | source
//
// Six-stage pipeline: one transaction per cycle while no output stall backs up to the input.
// Stages: cell hash premultiply, lane sum and xorshift, mix multiply,
// feature point and distance, row minimum, final minimum and scaling.
// Each stage holds while the one after it is full and stalled; bubbles collapse.
// Reset empties the pipeline; payload registers are not reset.
module worley_noise_2d_manhattan_q15_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] x_pos,
	input  logic signed [31:0] y_pos,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [14:0] noise_value
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	wn2d_pkg::frac_t fx_s1, fy_s1, fx_s2, fy_s2, fx_s3, fy_s3;
	wn2d_pkg::word_t hx_s1, hy_s1;
	wn2d_pkg::word_t n_s2 [wn2d_pkg::LANES];
	wn2d_pkg::word_t m_s3 [wn2d_pkg::LANES];
	wn2d_pkg::dist_t d_s4 [wn2d_pkg::LANES];
	wn2d_pkg::dist_t r_s5 [wn2d_pkg::ROWS];
	logic [14:0]     noise_s6;

	wn2d_pkg::word_t base_x, base_y, mul_x, mul_y;
	wn2d_pkg::word_t n_nx [wn2d_pkg::LANES];
	wn2d_pkg::word_t m_nx [wn2d_pkg::LANES];
	wn2d_pkg::dist_t d_nx [wn2d_pkg::LANES];
	wn2d_pkg::dist_t r_nx [wn2d_pkg::ROWS];
	wn2d_pkg::dist_t best;

	assign rdy_s6   = !v_s6 || !out_stall;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// stage 1: cell index times hash multipliers
	assign base_x = wn2d_pkg::word_t'(x_pos >>> 15);
	assign base_y = wn2d_pkg::word_t'(y_pos >>> 15);
	assign mul_x  = wn2d_pkg::word_t'(base_x * wn2d_pkg::HASH_MUL_X);
	assign mul_y  = wn2d_pkg::word_t'(base_y * wn2d_pkg::HASH_MUL_Y);

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			fx_s1 <= x_pos[14:0];
			fy_s1 <= y_pos[14:0];
			hx_s1 <= mul_x;
			hy_s1 <= mul_y;
		end
	end

	// stage 2: per-neighbor hash input, first xorshift
	always_comb begin
		wn2d_pkg::word_t n;
		for (int oy = 0; oy < 3; oy++) begin
			for (int ox = 0; ox < 3; ox++) begin
				n = hx_s1 + hy_s1
					+ wn2d_pkg::hash_off(2'(ox), wn2d_pkg::HASH_MUL_X)
					+ wn2d_pkg::hash_off(2'(oy), wn2d_pkg::HASH_MUL_Y);
				n_nx[oy*3 + ox] = n ^ (n >> 13);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			n_s2  <= n_nx;
		end
	end

	// stage 3: mix multiply
	always_comb begin
		for (int l = 0; l < wn2d_pkg::LANES; l++)
			m_nx[l] = wn2d_pkg::word_t'(n_s2[l] * wn2d_pkg::HASH_MIX);
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			m_s3  <= m_nx;
		end
	end

	// stage 4: feature point and Manhattan distance.
	// px - ptx reduces to frac - feature - cell offset, which never wraps.
	always_comb begin
		logic [15:0]        h;
		logic signed [17:0] dx, dy;
		logic        [16:0] ax, ay;
		for (int oy = 0; oy < 3; oy++) begin
			for (int ox = 0; ox < 3; ox++) begin
				h  = m_s3[oy*3 + ox][15:0] ^ m_s3[oy*3 + ox][31:16];
				dx = $signed({3'b000, fx_s3}) - $signed({3'b000, h[7:0], 7'd0})
					- wn2d_pkg::cell_off(2'(ox));
				dy = $signed({3'b000, fy_s3}) - $signed({3'b000, h[15:8], 7'd0})
					- wn2d_pkg::cell_off(2'(oy));
				ax = dx[17] ? 17'(-dx) : dx[16:0];
				ay = dy[17] ? 17'(-dy) : dy[16:0];
				d_nx[oy*3 + ox] = ax + ay;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) d_s4 <= d_nx;
	end

	// stage 5: minimum of each row
	always_comb begin
		for (int r = 0; r < wn2d_pkg::ROWS; r++)
			r_nx[r] = wn2d_pkg::dmin(wn2d_pkg::dmin(d_s4[r*3], d_s4[r*3 + 1]), d_s4[r*3 + 2]);
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) r_s5 <= r_nx;
	end

	// stage 6: overall minimum; (best << 15) goes negative once best reaches 2^16
	assign best = wn2d_pkg::dmin(wn2d_pkg::dmin(r_s5[0], r_s5[1]), r_s5[2]);

	always_ff @(posedge clk) begin
		if (rdy_s6) noise_s6 <= best[16] ? 15'd0 : best[15:1];
	end

	assign out_valid   = v_s6;
	assign noise_value = noise_s6;

`include "worley_noise_2d_manhattan_q15_top_assert.svh"

	`WN_ASSERT_NOW(a_stall_only_full, in_stall, v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6, "input stalled with a bubble in the pipeline")
	`WN_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v_s1, "accepted transaction did not enter stage 1")
	`WN_ASSERT_NEXT(a_tail_held, v_s5 && v_s6 && out_stall, v_s5 && v_s6, "transaction lost at the output under stall")
	`WN_ASSERT_NEXT(a_tail_moves, v_s5 && rdy_s6, v_s6, "stage 5 transaction did not reach the output")

endmodule

// File: test/worley_noise_2d_manhattan_q15_top_tb.sv
// Self-checking testbench for worley_noise_2d_manhattan_q15_top: corner coordinates, then
// random coordinate pairs, each result checked against an in-bench Manhattan Worley predictor.
// Depends only on the block's RTL; random idling on both valid/stall channels.
`timescale 1ns / 100ps

module worley_noise_2d_manhattan_q15_top_tb;

	localparam logic [31:0] MUL_CELL_X  = 32'd374761393;
	localparam logic [31:0] MUL_CELL_Y  = 32'd668265263;
	localparam logic [31:0] MUL_AVAL    = 32'd1274126177;
	localparam int          RANDOM_ITEMS = 750;
	localparam int          TIMEOUT_NS   = 2_000_000;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
	} coord_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [14:0] noise;
	} noise_due_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic signed [31:0] x_pos     = '0;
	logic signed [31:0] y_pos     = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic        [14:0] noise_value;

	noise_due_t noise_due[$];
	noise_due_t oldest;
	int         errors    = 0;
	int         hold_left = 0;
	bit         tx_calm   = 1'b0;
	bit         rx_calm   = 1'b0;

	// extremes, sign flips, cell edges and wrap-around corners
	coord_t corner_cases [15] = '{
		'{32'h0000_0000, 32'h0000_0000},
		'{32'h8000_0000, 32'h8000_0000},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF},
		'{32'h8000_0000, 32'h7FFF_FFFF},
		'{32'h7FFF_FFFF, 32'h8000_0000},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{32'h0000_7FFF, 32'h0000_8000},
		'{32'hFFFF_8000, 32'h0000_0000},
		'{32'h5555_5555, 32'hAAAA_AAAA},
		'{32'hAAAA_AAAA, 32'h5555_5555},
		'{32'h7FFF_8000, 32'h8000_7FFF},
		'{32'h8000_7FFF, 32'h7FFF_8000},
		'{32'h0001_0000, 32'hFFFE_FFFF},
		'{32'h4000_0000, 32'hC000_0000},
		'{32'h0000_3F80, 32'h0000_7F80}
	};

	worley_noise_2d_manhattan_q15_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.noise_value (noise_value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// nearest feature point over the 3x3 cell neighborhood, all math mod 2^32
	function automatic logic [14:0] nearest_feature_noise(input logic [31:0] px,
			input logic [31:0] py);
		logic [31:0] cell_x, cell_y, gx, gy, mix, hv, ptx, pty, dx, dy, span, best, scaled;
		int          oy, ox;
		best   = 32'h7FFF_FFFF;
		cell_x = {{15{px[31]}}, px[31:15]};
		cell_y = {{15{py[31]}}, py[31:15]};
		for (oy = -1; oy <= 1; oy++) begin
			for (ox = -1; ox <= 1; ox++) begin
				gx  = cell_x + 32'(ox);
				gy  = cell_y + 32'(oy);
				mix = gx * MUL_CELL_X + gy * MUL_CELL_Y;
				mix = (mix ^ (mix >> 13)) * MUL_AVAL;
				hv  = (mix ^ (mix >> 16)) & 32'h0000_FFFF;
				ptx = (gx << 15) + {17'd0, hv[7:0], 7'd0};
				pty = (gy << 15) + {17'd0, hv[15:8], 7'd0};
				dx  = px - ptx;
				dy  = py - pty;
				if (dx[31])
					dx = 32'd0 - dx;
				if (dy[31])
					dy = 32'd0 - dy;
				span = dx + dy;
				if ($signed(span) < $signed(best))
					best = span;
			end
		end
		scaled = best << 15;
		return scaled[31] ? 15'd0 : scaled[30:16];
	endfunction

	function automatic logic [31:0] pick_coord();
		logic [31:0] seed;
		seed = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5:       return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
			6:          return {seed[16:0], 15'd0} + $urandom_range(0, 4) - 32'd2;
			7: begin
				if ($urandom_range(0, 1))
					return 32'h7FFF_FFFF - $urandom_range(0, 32'h2_0000);
				else
					return 32'h8000_0000 + $urandom_range(0, 32'h2_0000);
			end
			default:    return {seed[16:0], seed[24:17], 7'd0};
		endcase
	endfunction

	// valid stays high across back-to-back transactions; lowered only for a gap
	task automatic drive_coord(input logic [31:0] x, input logic [31:0] y);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_pos    <= x;
		y_pos    <= y;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (noise_due.size() != 0)
			@(posedge clk);
	endtask

	// input acceptance, output check and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (in_valid && !in_stall)
				noise_due.push_back('{x: x_pos, y: y_pos,
					noise: nearest_feature_noise(x_pos, y_pos)});
			if (out_valid && !out_stall) begin
				if (noise_due.size() == 0) begin
					$display("%0t: unexpected transaction, noise_value=%0d", $time, noise_value);
					errors++;
				end else begin
					oldest = noise_due.pop_front();
					if (noise_value !== oldest.noise) begin
						$display("%0t: noise_value mismatch at x=%h y=%h: expected %0d, got %0d",
							$time, oldest.x, oldest.y, oldest.noise, noise_value);
						errors++;
					end
				end
				hold_left = rx_calm ? 0 : $urandom_range(0, 7);
			end else if (hold_left != 0) begin
				hold_left--;
			end
			out_stall <= (hold_left != 0);
		end
	end

	initial begin
		int idx;
		int drain_cycles;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (idx = 0; idx < $size(corner_cases); idx++)
			drive_coord(corner_cases[idx].x, corner_cases[idx].y);
		hold_until_drained();

		for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
			if (idx % 60 == 0) begin
				tx_calm = ($urandom_range(0, 3) == 0);
				rx_calm = ($urandom_range(0, 3) == 0);
			end
			if (idx == RANDOM_ITEMS / 2)
				hold_until_drained();
			drive_coord(pick_coord(), pick_coord());
		end
		in_valid <= 1'b0;

		drain_cycles = 0;
		@(posedge clk);
		while (noise_due.size() != 0 && drain_cycles < 2000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (16) @(posedge clk);
		if (noise_due.size() != 0) begin
			$display("%0t: %0d expected transactions never arrived", $time, noise_due.size());
			errors++;
		end
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAIL");
		$finish;
	end

endmodule
